@@ design/fpba_pkg.sv @@
// shared types and constants for the fit policy block allocator
package fpba_pkg;

    // defaults for the top level parameters
    localparam int DEF_NUM_BLOCKS = 16;
    localparam int DEF_SIZE_BITS  = 16;

    // fixed port field widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int ENTRY_W     = 4;
    localparam int SIZE_W      = 16;
    localparam int COUNT_W     = 5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_POLICY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT  = 2'd1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    // item kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_NEXT  = 2'd3
    } fpba_policy_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } fpba_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic commit;
    } fpba_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_request;
        logic count_zero;
        logic scan_last;
        logic out_busy;
    } fpba_status_t;

endpackage

@@ design/fpba_ctrl.sv @@
// sequencing state machine for the fit policy block allocator
module fpba_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fpba_pkg::fpba_status_t status,
    output fpba_pkg::fpba_cmd_t    cmd
);
    import fpba_pkg::*;

    fpba_state_t state_reg;
    fpba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (status.in_request && !status.count_zero)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last compare lands this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/fpba_datapath.sv @@
// free size table, scan compare, config registers and result register
module fpba_datapath #(
    parameter int NUM_BLOCKS = fpba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fpba_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                kind,
    input  logic [fpba_pkg::ENTRY_W-1:0]        entry_index,
    input  logic [fpba_pkg::SIZE_W-1:0]         size_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                granted,
    output logic [fpba_pkg::ENTRY_W-1:0]        block_index,
    output logic [fpba_pkg::SIZE_W-1:0]         remaining,
    input  fpba_pkg::fpba_cmd_t                 cmd,
    output fpba_pkg::fpba_status_t              status
);
    import fpba_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    // configuration
    fpba_policy_t       policy_reg;
    logic [COUNT_W-1:0] blocks_reg;
    logic [CNT_W-1:0]   count;

    // captured item
    logic                 kind_reg;
    logic [ENTRY_W-1:0]   idx_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [31:0]          size_in_wide;
    logic [31:0]          idx_wide;
    logic                 idx_ok;
    logic [IDX_W-1:0]     load_addr;

    // table
    logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_data;

    // scan
    logic [IDX_W-1:0]     pos_reg;
    logic [IDX_W-1:0]     pos_next;
    logic [CNT_W-1:0]     pos_inc;
    logic [CNT_W-1:0]     left_reg;
    logic [IDX_W-1:0]     ptr_reg;
    logic [IDX_W-1:0]     start_pos;

    // compare stage
    logic                 rd_live_reg;
    logic [SIZE_BITS-1:0] rd_data_reg;
    logic                 rd_vbit_reg;
    logic [IDX_W-1:0]     rd_pos_reg;
    logic [SIZE_BITS-1:0] rd_eff;
    logic                 fits;
    logic                 take;
    logic                 found_reg;
    logic [SIZE_BITS-1:0] best_val_reg;
    logic [IDX_W-1:0]     best_pos_reg;
    logic [SIZE_BITS-1:0] diff;

    // result
    logic                 out_valid_reg;
    logic                 granted_reg;
    logic [ENTRY_W-1:0]   block_reg;
    logic [SIZE_W-1:0]    remaining_reg;
    logic [31:0]          pos_wide;
    logic [31:0]          val_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            blocks_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_POLICY)
            begin
                policy_reg <= fpba_policy_t'(cfg_data[1:0]);
            end
            else if (cfg_index == REG_COUNT)
            begin
                blocks_reg <= cfg_data;
            end
        end
    end

    // counts above the table clamp to the table depth
    always_comb
    begin
        if (32'(blocks_reg) > NUM_BLOCKS)
        begin
            count = CNT_W'(NUM_BLOCKS);
        end
        else
        begin
            count = CNT_W'(blocks_reg);
        end
    end

    assign size_in_wide = 32'(size_value);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            idx_reg  <= entry_index;
            size_reg <= size_in_wide[SIZE_BITS-1:0];
        end
    end

    assign idx_wide  = 32'(idx_reg);
    assign idx_ok    = idx_wide < NUM_BLOCKS;
    assign load_addr = idx_wide[IDX_W-1:0];

    // scan address generation, wraps at the active count
    assign start_pos = ((policy_reg == POL_NEXT) && (CNT_W'(ptr_reg) < count))
                       ? ptr_reg : '0;
    assign pos_inc   = CNT_W'(pos_reg) + CNT_W'(1);
    assign pos_next  = (pos_inc == count) ? '0 : pos_inc[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pos_reg  <= start_pos;
            left_reg <= count - CNT_W'(1);
        end
        else if (cmd.scan_step)
        begin
            pos_reg  <= pos_next;
            left_reg <= left_reg - CNT_W'(1);
        end
    end

    // table write port, shared by loads and grants
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = best_pos_reg;
        wr_data = diff;
        if (cmd.commit)
        begin
            if (kind_reg == KIND_LOAD)
            begin
                wr_en   = idx_ok;
                wr_addr = load_addr;
                wr_data = size_reg;
            end
            else
            begin
                wr_en = found_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[pos_reg];
            rd_vbit_reg <= valid_reg[pos_reg];
            rd_pos_reg  <= pos_reg;
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_live_reg <= 1'b0;
            ptr_reg     <= '0;
        end
        else
        begin
            rd_live_reg <= cmd.scan_step;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.commit)
            begin
                if (kind_reg == KIND_LOAD)
                begin
                    if (idx_ok)
                    begin
                        ptr_reg <= '0;
                    end
                end
                else if (found_reg && (policy_reg == POL_NEXT))
                begin
                    ptr_reg <= best_pos_reg;
                end
            end
        end
    end

    // entries arrive in search order, so the first fit wins for first and next fit
    assign rd_eff = rd_vbit_reg ? rd_data_reg : '0;
    assign fits   = rd_eff >= size_reg;

    always_comb
    begin
        take = 1'b0;
        if (rd_live_reg && fits)
        begin
            priority if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (policy_reg == POL_BEST)
            begin
                take = rd_eff < best_val_reg;
            end
            else if (policy_reg == POL_WORST)
            begin
                take = rd_eff > best_val_reg;
            end
            else
            begin
                take = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_val_reg <= rd_eff;
            best_pos_reg <= rd_pos_reg;
        end
    end

    assign diff = best_val_reg - size_reg;

    // result register
    assign pos_wide = 32'(best_pos_reg);
    assign val_wide = (kind_reg == KIND_LOAD) ? 32'(size_reg) : 32'(diff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if ((kind_reg == KIND_LOAD) ? idx_ok : found_reg)
            begin
                granted_reg   <= 1'b1;
                block_reg     <= (kind_reg == KIND_LOAD) ? idx_reg : pos_wide[ENTRY_W-1:0];
                remaining_reg <= val_wide[SIZE_W-1:0];
            end
            else
            begin
                granted_reg   <= 1'b0;
                block_reg     <= '0;
                remaining_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign granted     = granted_reg;
    assign block_index = block_reg;
    assign remaining   = remaining_reg;

    assign status.in_request = (kind == KIND_REQUEST);
    assign status.count_zero = (count == '0);
    assign status.scan_last  = (left_reg == '0);
    assign status.out_busy   = out_valid_reg && !out_ready;

`ifndef SYNTHESIS
    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !out_ready))
        else $error("commit while result slot still occupied");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (CNT_W'(pos_reg) < count))
        else $error("scan address beyond active count");

    a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg && (kind_reg == KIND_REQUEST)) |-> (best_val_reg >= size_reg))
        else $error("chosen block smaller than request");

    a_result_follows_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not raise result valid");
`endif

endmodule

@@ design/fit_policy_block_allocator.sv @@
// top level of the fit policy block allocator
// Allocator over a table of NUM_BLOCKS free sizes. A load transaction (kind 0) writes one
// entry, if its index lies in the table, and sends the next-fit pointer back to block 0;
// a request transaction (kind 1) picks a block by the policy register (first, best, worst
// or next fit), subtracts the request from it and reports the block and what is left, or
// granted 0 when nothing fits. The table has a single read port; a request searches it,
// reading one entry per cycle through a registered read, followed by the last compare and
// then the update. A request with a zero block count skips the search. Items are handled
// one at a time. The result sits in an output register, so a new item is accepted while
// the previous result waits; the update stalls only if that result has still not been
// taken. Configuration writes land at once and must be made while no item is in flight.
// The table reads as all zero after reset, by its valid bits, with no clearing pass.
module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = fpba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [fpba_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [fpba_pkg::ENTRY_W-1:0]     entry_index,
    input  logic [fpba_pkg::SIZE_W-1:0]      size_value,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             granted,
    output logic [fpba_pkg::ENTRY_W-1:0]     block_index,
    output logic [fpba_pkg::SIZE_W-1:0]      remaining
);
    import fpba_pkg::*;

    // command and status between sequencer and datapath
    fpba_cmd_t    cmd;
    fpba_status_t status;

    // sequencer: idle, scan, drain of the read pipeline, commit
    fpba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // table, compare stage, pointer, config and result registers
    fpba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .entry_index (entry_index),
        .size_value  (size_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .granted     (granted),
        .block_index (block_index),
        .remaining   (remaining),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
